// ===== rtl/core/vbpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_pkg
// Shared types and constants of the ventilator breath phase timer.
// ----------------------------------------------------------------------------
package vbpt_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TIME  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BREATH_RATE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IE_RATIO   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VENT_PRESS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEEP       = 3'd4;

    localparam logic [19:0] STEP_TIME_RST   = 20'd20000;
    localparam logic [10:0] BREATH_RATE_RST = 11'd120;
    localparam logic [15:0] IE_RATIO_RST    = 16'd128;
    localparam logic [15:0] VENT_PRESS_RST  = 16'd3840;
    localparam logic [15:0] PEEP_RST        = 16'd768;

    localparam logic [29:0] US_PER_MIN_TENTHS = 30'd600000000;
    localparam logic [16:0] ONE_Q8            = 17'd256;
    localparam logic [10:0] SEVERITY_FULL     = 11'd1024;
    localparam logic [30:0] ELAPSED_MAX       = 31'h7FFF_FFFF;

    localparam int DIV_NUM_W = 46;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] LEN_DIV_STEPS  = 6'd30;
    localparam logic [DIV_CNT_W-1:0] INSP_DIV_STEPS = 6'd46;

    typedef struct packed {
        logic load_in;
        logic update;
        logic len_start;
        logic len_zero;
        logic len_store;
        logic mul;
        logic insp_start;
        logic insp_store;
        logic phase;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic off;
        logic restart;
        logic rate_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/vbpt_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_divider
// Restoring divider, one quotient bit per cycle, step count set at start.
// ----------------------------------------------------------------------------
module vbpt_divider
    import vbpt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start_i,
    input  wire logic [DIV_NUM_W-1:0] dividend_i,
    input  wire logic [DIV_DEN_W-1:0] divisor_i,
    input  wire logic [DIV_CNT_W-1:0] steps_i,
    output logic                      done_o,
    output logic [DIV_NUM_W-1:0]      quotient_o
);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            quo_next  = dividend_i;
            rem_next  = '0;
            den_next  = divisor_i;
            cnt_next  = steps_i;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg})
                            : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done_o     = done_reg;
    assign quotient_o = quo_reg;

`ifndef ASSERT_OFF
    a_no_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/vbpt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_datapath
// Settings, cycle timing state, shared divider and output register.
// ----------------------------------------------------------------------------
module vbpt_datapath
    import vbpt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_off_i,
    input  wire logic [10:0]           in_sev_i,
    input  wire dp_cmd_t               cmd_i,
    output dp_status_t                 status_o,
    input  wire logic                  out_ready_i,
    output logic                       out_valid_o,
    output logic                       out_inhale_o,
    output logic [15:0]                out_drive_o,
    output logic                       out_dvalid_o
);

    logic [19:0] step_reg;
    logic [10:0] rate_reg;
    logic [15:0] ie_reg;
    logic [15:0] vent_reg;
    logic [15:0] peep_reg;

    logic [30:0] elapsed_reg, elapsed_next;
    logic [29:0] len_reg, len_next;
    logic [29:0] insp_reg, insp_next;
    logic        phase_reg, phase_next;
    logic        off_reg;
    logic [10:0] sev_reg;
    logic [45:0] prod_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_inhale_reg;
    logic [15:0] out_drive_reg;
    logic        out_dvalid_reg;

    logic [31:0] sum;
    logic [30:0] sum_sat;
    logic        restart;
    logic        out_free;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic [10:0] sev_clamp;
    logic [10:0] keep_factor;
    logic [15:0] sel_press;
    logic [26:0] drive_prod;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_TIME_RST;
            rate_reg <= BREATH_RATE_RST;
            ie_reg   <= IE_RATIO_RST;
            vent_reg <= VENT_PRESS_RST;
            peep_reg <= PEEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STEP_TIME:   step_reg <= cfg_wdata;
                CFG_BREATH_RATE: rate_reg <= cfg_wdata[10:0];
                CFG_IE_RATIO:    ie_reg   <= cfg_wdata[15:0];
                CFG_VENT_PRESS:  vent_reg <= cfg_wdata[15:0];
                CFG_PEEP:        peep_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign sum     = {1'b0, elapsed_reg} + {12'b0, step_reg};
    assign sum_sat = sum[31] ? ELAPSED_MAX : sum[30:0];
    assign restart = sum_sat > {1'b0, len_reg};

    // shared divider operands
    assign div_start = cmd_i.len_start | cmd_i.insp_start;
    assign div_num   = cmd_i.len_start ? {US_PER_MIN_TENTHS, 16'b0} : prod_reg;
    assign div_den   = cmd_i.len_start ? {6'b0, rate_reg} : ({1'b0, ie_reg} + ONE_Q8);
    assign div_steps = cmd_i.len_start ? LEN_DIV_STEPS : INSP_DIV_STEPS;

    vbpt_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (div_num),
        .divisor_i  (div_den),
        .steps_i    (div_steps),
        .done_o     (div_done),
        .quotient_o (div_quo)
    );

    always_comb begin
        elapsed_next = elapsed_reg;
        len_next     = len_reg;
        insp_next    = insp_reg;
        phase_next   = phase_reg;
        if (cmd_i.update) begin
            if (off_reg || restart) begin
                elapsed_next = '0;
            end else begin
                elapsed_next = sum_sat;
            end
        end
        if (cmd_i.len_zero) begin
            len_next = '0;
        end else if (cmd_i.len_store) begin
            len_next = div_quo[29:0];
        end
        if (cmd_i.insp_store) begin
            insp_next = div_quo[29:0];
        end
        if (cmd_i.phase) begin
            phase_next = off_reg | (elapsed_reg < {1'b0, insp_reg});
        end
    end

    // drive pressure scaling
    assign sev_clamp   = (sev_reg > SEVERITY_FULL) ? SEVERITY_FULL : sev_reg;
    assign keep_factor = SEVERITY_FULL - sev_clamp;
    assign sel_press   = phase_reg ? vent_reg : peep_reg;
    assign drive_prod  = {11'b0, sel_press} * {16'b0, keep_factor};

    assign out_free = !out_valid_reg || out_ready_i;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_ready_i) begin
            out_valid_next = 1'b0;
        end
        if (cmd_i.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            len_reg       <= '0;
            insp_reg      <= '0;
            phase_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            elapsed_reg   <= elapsed_next;
            len_reg       <= len_next;
            insp_reg      <= insp_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
        if (cmd_i.load_in) begin
            off_reg <= in_off_i;
            sev_reg <= in_sev_i;
        end
        if (cmd_i.mul) begin
            prod_reg <= {30'b0, ie_reg} * {16'b0, len_reg};
        end
        if (cmd_i.emit) begin
            out_inhale_reg <= phase_reg;
            out_drive_reg  <= off_reg ? 16'd0 : drive_prod[25:10];
            out_dvalid_reg <= !off_reg;
        end
    end

    assign status_o.off       = off_reg;
    assign status_o.restart   = restart;
    assign status_o.rate_zero = (rate_reg == 11'd0);
    assign status_o.div_done  = div_done;
    assign status_o.out_free  = out_free;

    assign out_valid_o  = out_valid_reg;
    assign out_inhale_o = out_inhale_reg;
    assign out_drive_o  = out_drive_reg;
    assign out_dvalid_o = out_dvalid_reg;

`ifndef ASSERT_OFF
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.update && restart |=> elapsed_reg == '0)
        else $error("cycle restart did not clear elapsed time");

    a_off_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.emit && off_reg |=> out_valid_reg && out_inhale_reg &&
            out_drive_reg == '0 && !out_dvalid_reg)
        else $error("machine off result malformed");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/vbpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_ctrl
// Tick sequencer: update, optional cycle restart divisions, phase, result.
// ----------------------------------------------------------------------------
module vbpt_ctrl
    import vbpt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid_i,
    output logic            in_ready_o,
    input  wire dp_status_t status_i,
    output dp_cmd_t         cmd_o
);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_UPDATE     = 9'b000000010,
        ST_DIV_LEN    = 9'b000000100,
        ST_MUL        = 9'b000001000,
        ST_INSP_START = 9'b000010000,
        ST_DIV_INSP   = 9'b000100000,
        ST_PHASE      = 9'b001000000,
        ST_EMIT       = 9'b010000000,
        ST_SPARE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        in_ready_o = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready_o = 1'b1;
                if (in_valid_i) begin
                    cmd_o.load_in = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd_o.update = 1'b1;
                if (status_i.off || !status_i.restart) begin
                    state_next = ST_PHASE;
                end else if (status_i.rate_zero) begin
                    cmd_o.len_zero = 1'b1;
                    state_next     = ST_MUL;
                end else begin
                    cmd_o.len_start = 1'b1;
                    state_next      = ST_DIV_LEN;
                end
            end
            ST_DIV_LEN: begin
                if (status_i.div_done) begin
                    cmd_o.len_store = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd_o.mul  = 1'b1;
                state_next = ST_INSP_START;
            end
            ST_INSP_START: begin
                cmd_o.insp_start = 1'b1;
                state_next       = ST_DIV_INSP;
            end
            ST_DIV_INSP: begin
                if (status_i.div_done) begin
                    cmd_o.insp_store = 1'b1;
                    state_next       = ST_PHASE;
                end
            end
            ST_PHASE: begin
                cmd_o.phase = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_tick_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_i && in_ready_o |=> !in_ready_o)
        else $error("second tick taken while one is in flight");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.emit |-> status_i.out_free)
        else $error("result written over a pending one");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ventilator_breath_phase_timer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ventilator_breath_phase_timer
// Sequence: an ordinary tick passes the update, phase and emit states after the tick transfer.
// A tick that ends a breath cycle also runs the shared serial divider: 30 steps for
// the cycle length (skipped when the rate is zero) and 46 for the inspiration time.
// One tick in flight at a time: the next is taken once the result is written, also while it waits.
// Reset (aresetn low, synchronous): settings to defaults, timers cleared,
// phase set to inhale, no pending result.
// ----------------------------------------------------------------------------
module ventilator_breath_phase_timer
    import vbpt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // [10:0] loss_severity
    input  wire logic                  s_tuser,  // [0] machine_off
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,  // [0] inhaling, [16:1] drive_pressure_q8
    output logic                       m_tuser   // [0] drive_valid
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        out_inhale;
    logic [15:0] out_drive;

    vbpt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_tvalid),
        .in_ready_o (s_tready),
        .status_i   (status),
        .cmd_o      (cmd)
    );

    vbpt_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_off_i     (s_tuser),
        .in_sev_i     (s_tdata[10:0]),
        .cmd_i        (cmd),
        .status_o     (status),
        .out_ready_i  (m_tready),
        .out_valid_o  (m_tvalid),
        .out_inhale_o (out_inhale),
        .out_drive_o  (out_drive),
        .out_dvalid_o (m_tuser)
    );

    assign m_tdata = {7'b0, out_drive, out_inhale};

endmodule
`default_nettype wire

// ===== dv/tb_ventilator_breath_phase_timer.sv =====
// ----------------------------------------------------------------------------
// tb_ventilator_breath_phase_timer
// Tick-level check of the breath phase timer. Each accepted tick is run
// through a local model of the cycle timer, the phase decision and the
// pressure scaling. The model's phase and drive pressure are queued, and
// every result transfer is compared against them in order. Directed corners
// come first, then a receiver hold-off and a series of random settings with
// random tick content and random idle time on both streams.
// ----------------------------------------------------------------------------
module tb_ventilator_breath_phase_timer;
    import vbpt_pkg::*;

    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES     = 100;
    localparam int unsigned RANDOM_PHASES    = 10;
    localparam int unsigned PHASE_TICKS      = 150;
    localparam int unsigned STALL_TICKS      = 40;

    typedef struct {
        logic        inhaling;
        logic [15:0] drive_q8;
        logic        drive_valid;
    } phase_pressure_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;  // [10:0] loss_severity
    logic                  s_tuser = 1'b0;  // [0] machine_off
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;  // [0] inhaling, [16:1] drive_pressure_q8
    logic                  m_tuser;  // [0] drive_valid

    // settings and timer state of the local model
    logic [19:0] step_us;
    logic [10:0] rate_tenths;
    logic [15:0] ie_q8;
    logic [15:0] vent_q8;
    logic [15:0] peep_level_q8;
    logic [30:0] elapsed_us;
    logic [29:0] breath_len_us;
    logic [29:0] inspire_us;
    logic        inhale_now;

    phase_pressure_t phase_pressure_q[$];
    phase_pressure_t due;

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned ready_hold_left = 0;
    int unsigned sink_gap;
    logic        long_hold_req = 1'b0;
    logic        sink_steady = 1'b0;
    logic        source_steady = 1'b0;

    ventilator_breath_phase_timer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_timer_model();
        step_us       = STEP_TIME_RST;
        rate_tenths   = BREATH_RATE_RST;
        ie_q8         = IE_RATIO_RST;
        vent_q8       = VENT_PRESS_RST;
        peep_level_q8 = PEEP_RST;
        elapsed_us    = '0;
        breath_len_us = '0;
        inspire_us    = '0;
        inhale_now    = 1'b1;
    endfunction

    function automatic phase_pressure_t next_phase_pressure(input logic off,
                                                            input logic [10:0] sev);
        phase_pressure_t res;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] level;
        logic [63:0] kept;
        if (off) begin
            inhale_now = 1'b1;
            elapsed_us = '0;
            res.inhaling = 1'b1;
            res.drive_q8 = '0;
            res.drive_valid = 1'b0;
            return res;
        end
        sum = 64'(elapsed_us) + 64'(step_us);
        elapsed_us = (sum > 64'(ELAPSED_MAX)) ? ELAPSED_MAX : sum[30:0];
        if (31'(breath_len_us) < elapsed_us) begin
            // end of breath cycle: new length from rate, new inspiration time
            elapsed_us = '0;
            len = (rate_tenths != 0) ? 64'd600000000 / 64'(rate_tenths) : 64'd0;
            breath_len_us = len[29:0];
            len = (64'(ie_q8) * 64'(breath_len_us)) / (64'd256 + 64'(ie_q8));
            inspire_us = len[29:0];
        end
        inhale_now = elapsed_us < 31'(inspire_us);
        kept = (sev > 11'd1024) ? 64'd0 : 64'd1024 - 64'(sev);
        level = inhale_now ? 64'(vent_q8) : 64'(peep_level_q8);
        level = (level * kept) >> 10;
        res.inhaling = inhale_now;
        res.drive_q8 = level[15:0];
        res.drive_valid = 1'b1;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [10:0] pick_severity();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 11'd0;
        if (roll < 22) return 11'd1024;
        if (roll < 32) return 11'($urandom_range(1025, 2047));
        if (roll < 40) return 11'($urandom);
        return 11'($urandom_range(0, 1024));
    endfunction

    function automatic logic [19:0] pick_extreme16(input int unsigned roll);
        if (roll < 10) return 20'd0;
        if (roll < 20) return 20'd65535;
        return 20'($urandom_range(0, 65535));
    endfunction

    task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr,
                                 input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            CFG_STEP_TIME:   step_us       = value[19:0];
            CFG_BREATH_RATE: rate_tenths   = value[10:0];
            CFG_IE_RATIO:    ie_q8         = value[15:0];
            CFG_VENT_PRESS:  vent_q8       = value[15:0];
            CFG_PEEP:        peep_level_q8 = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic offer_tick(input logic off, input logic [10:0] sev);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, sev};
        s_tuser  <= off;
        do @(posedge aclk); while (!s_tready);
        phase_pressure_q.push_back(next_phase_pressure(off, sev));
        gap = source_steady ? 0 : pick_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // stop offering ticks and wait until every queued result has been seen
    task automatic settle_ventilator();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (phase_pressure_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [19:0] step, input logic [10:0] rate,
                                  input logic [15:0] ie, input logic [15:0] vent,
                                  input logic [15:0] peep);
        settle_ventilator();
        write_setting(CFG_STEP_TIME, step);
        write_setting(CFG_BREATH_RATE, 20'(rate));
        write_setting(CFG_IE_RATIO, 20'(ie));
        write_setting(CFG_VENT_PRESS, 20'(vent));
        write_setting(CFG_PEEP, 20'(peep));
    endtask

    task automatic test_directed_corners();
        // defaults: first tick ends the zero-length cycle, severity limits, machine off
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd1024);
        offer_tick(1'b0, 11'd2047);
        offer_tick(1'b0, 11'd1025);
        offer_tick(1'b0, 11'd512);
        offer_tick(1'b1, 11'd0);
        offer_tick(1'b1, 11'd2047);
        offer_tick(1'b0, 11'd1023);
        // largest step, fastest rate, largest ratio and pressure
        apply_settings(20'd1000000, 11'd1200, 16'hFFFF, 16'hFFFF, 16'h0000);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd1);
        // rate zero, ratio zero: every tick with the machine on restarts and exhales
        apply_settings(20'd1000000, 11'd0, 16'h0000, 16'h0000, 16'hFFFF);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd1023);
        offer_tick(1'b1, 11'd0);
        offer_tick(1'b0, 11'd0);
        // zero step: elapsed time stands still
        settle_ventilator();
        write_setting(CFG_STEP_TIME, 20'd0);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd0);
        // slowest rate, smallest step
        apply_settings(20'd1, 11'd1, 16'd256, 16'd1, 16'd1);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd0);
        offer_tick(1'b0, 11'd1024);
    endtask

    task automatic test_output_hold_off();
        apply_settings(20'd300000, 11'd300, 16'd200, 16'd5000, 16'd1200);
        long_hold_req = 1'b1;
        source_steady = 1'b1;
        for (int i = 0; i < STALL_TICKS; i++) begin
            offer_tick(($urandom_range(0, 19) == 0), pick_severity());
        end
        source_steady = 1'b0;
        settle_ventilator();
    endtask

    task automatic test_random_settings();
        int unsigned roll;
        logic [19:0] step;
        logic [10:0] rate;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) step = 20'd1;
            else if (roll < 20) step = 20'd1000000;
            else if (roll < 35) step = 20'($urandom_range(1, 1000));
            else step = 20'($urandom_range(1, 1000000));
            roll = $urandom_range(0, 99);
            if (roll < 10) rate = 11'd0;
            else if (roll < 20) rate = 11'd1200;
            else if (roll < 25) rate = 11'd1;
            else rate = 11'($urandom_range(1, 1200));
            roll = $urandom_range(0, 99);
            apply_settings(step, rate,
                           (roll >= 20 && roll < 60) ? 16'($urandom_range(0, 1024))
                                                     : 16'(pick_extreme16(roll)),
                           16'(pick_extreme16($urandom_range(0, 99))),
                           16'(pick_extreme16($urandom_range(0, 99))));
            source_steady = (ph % 4 == 3);
            sink_steady   = (ph % 4 == 3);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                offer_tick(($urandom_range(0, 99) < 4), pick_severity());
                if ($urandom_range(0, 99) == 0) settle_ventilator();
            end
            source_steady = 1'b0;
            sink_steady   = 1'b0;
        end
    endtask

    // receiver ready with random gaps and the requested long hold-off
    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            ready_hold_left = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (ready_hold_left != 0) begin
            ready_hold_left--;
            m_tready <= 1'b0;
        end else if (sink_steady) begin
            m_tready <= 1'b1;
        end else begin
            sink_gap = pick_gap();
            if (sink_gap != 0) begin
                ready_hold_left = sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest queued prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (phase_pressure_q.size() == 0) begin
                $error("result transfer with nothing queued: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                due = phase_pressure_q.pop_front();
                if (m_tdata[0] !== due.inhaling) begin
                    $error("inhaling: expected %0d, got %0d", due.inhaling, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[16:1] !== due.drive_q8) begin
                    $error("drive_pressure_q8: expected %0d, got %0d",
                           due.drive_q8, m_tdata[16:1]);
                    mismatches++;
                end
                if (m_tuser !== due.drive_valid) begin
                    $error("drive_valid: expected %0d, got %0d", due.drive_valid, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_timer_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_corners();
        test_output_hold_off();
        test_random_settings();
        settle_ventilator();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vbpt_pkg.sv
rtl/core/vbpt_divider.sv
rtl/core/vbpt_datapath.sv
rtl/core/vbpt_ctrl.sv
rtl/core/ventilator_breath_phase_timer.sv
dv/tb_ventilator_breath_phase_timer.sv
